// ----- rtl/rational_arith_unit_macros.svh -----
// Assertion macros for the rational arithmetic unit.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("assertion failed");
`define RAU_NEVER(lbl, ck, rn, expr) \
	`RAU_ASSERT(lbl, ck, rn, !(expr))
`else
`define RAU_ASSERT(lbl, ck, rn, prop)
`define RAU_NEVER(lbl, ck, rn, expr)
`endif
`endif

// ----- rtl/rau_pkg.sv -----
// Shared constants and types for the rational arithmetic unit.
// No dependencies; imported by every module of the block.
package rau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_W       = 32;
	localparam int DEN_W         = 31;
	localparam int OP_W          = 3;
	localparam int ST_W          = 2;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV = 3'd3;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic            vld;
		logic [ST_W-1:0] st;
		logic            neg;
	} ctl_t;

endpackage

// ----- rtl/rau_front.sv -----
// Front end: operand decode, cross products, overflow checks, sign move.
// Three pipeline stages; depends on rau_pkg.
module rau_front #(
	parameter int EW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rau_pkg::OP_W-1:0]      opcode,
	input  logic signed [rau_pkg::FIELD_W-1:0] first_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] first_den,
	input  logic signed [rau_pkg::FIELD_W-1:0] second_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] second_den,
	output rau_pkg::ctl_t                 ctl_o,
	output logic [EW-2:0]                 mag_o,
	output logic [EW-2:0]                 den_o
);
	import rau_pkg::*;

	localparam int M  = EW - 1;
	localparam int PW = 2 * EW;

	logic signed [EW-1:0] an, ad, bn, bd, mb0, mb2;
	logic                 is_bin;
	logic [ST_W-1:0]      st0;

	assign an = first_num[EW-1:0];
	assign ad = first_den[EW-1:0];
	assign bn = second_num[EW-1:0];
	assign bd = second_den[EW-1:0];
	assign is_bin = (opcode == OP_ADD) || (opcode == OP_SUB) || (opcode == OP_MUL) ||
		(opcode == OP_DIV);
	assign mb0 = (opcode == OP_MUL) ? bn : bd;
	assign mb2 = (opcode == OP_DIV) ? bn : bd;

	always_comb begin
		priority if (ad == '0 || (is_bin && bd == '0)) begin
			st0 = ST_ZERO_DEN;
		end else if (opcode == OP_DIV && bn == '0) begin
			st0 = ST_DIV_ZERO;
		end else begin
			st0 = ST_OK;
		end
	end

	// stage 1: products
	ctl_t                  ctl_s1;
	logic [OP_W-1:0]       op_s1;
	logic signed [PW-1:0]  m0_s1, m1_s1, m2_s1;
	logic [EW-1:0]         an_s1, ad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: in_valid, st: st0, neg: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= opcode;
			m0_s1 <= an * mb0;
			m1_s1 <= bn * ad;
			m2_s1 <= ad * mb2;
			an_s1 <= an;
			ad_s1 <= ad;
		end
	end

	// stage 2: range checks, sum or difference
	logic          f0, f1, f2, fs, ovf2;
	logic [EW:0]   sum;
	logic [EW-1:0] n2, d2;
	logic [ST_W-1:0] st2;

	assign f0 = m0_s1[PW-1:EW-1] == {(EW+1){m0_s1[EW-1]}};
	assign f1 = m1_s1[PW-1:EW-1] == {(EW+1){m1_s1[EW-1]}};
	assign f2 = m2_s1[PW-1:EW-1] == {(EW+1){m2_s1[EW-1]}};
	assign sum = (op_s1 == OP_SUB)
		? {m0_s1[EW-1], m0_s1[EW-1:0]} - {m1_s1[EW-1], m1_s1[EW-1:0]}
		: {m0_s1[EW-1], m0_s1[EW-1:0]} + {m1_s1[EW-1], m1_s1[EW-1:0]};
	assign fs = sum[EW] == sum[EW-1];

	always_comb begin
		n2   = m0_s1[EW-1:0];
		d2   = m2_s1[EW-1:0];
		ovf2 = 1'b0;
		priority if (op_s1 == OP_ADD || op_s1 == OP_SUB) begin
			n2   = sum[EW-1:0];
			ovf2 = !f0 || !f1 || !f2 || !fs;
		end else if (op_s1 == OP_MUL || op_s1 == OP_DIV) begin
			ovf2 = !f0 || !f2;
		end else begin
			n2 = an_s1;
			d2 = ad_s1;
		end
		if (ctl_s1.st != ST_OK) begin
			st2 = ctl_s1.st;
		end else if (ovf2) begin
			st2 = ST_OVERFLOW;
		end else begin
			st2 = ST_OK;
		end
	end

	ctl_t          ctl_s2;
	logic [EW-1:0] n_s2, d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= '{vld: ctl_s1.vld, st: st2, neg: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= n2;
			d_s2 <= d2;
		end
	end

	// stage 3: sign to numerator, magnitudes
	localparam logic [EW-1:0] MINV = {1'b1, {M{1'b0}}};

	logic          ovf3;
	logic [EW-1:0] nabs, dabs;
	logic [ST_W-1:0] st3;

	assign ovf3 = (n_s2 == MINV) || (d_s2 == MINV);
	assign nabs = n_s2[EW-1] ? -n_s2 : n_s2;
	assign dabs = d_s2[EW-1] ? -d_s2 : d_s2;
	assign st3  = (ctl_s2.st != ST_OK) ? ctl_s2.st : (ovf3 ? ST_OVERFLOW : ST_OK);

	ctl_t         ctl_s3;
	logic [M-1:0] mag_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= '{vld: ctl_s2.vld, st: st3, neg: n_s2[EW-1] ^ d_s2[EW-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= nabs[M-1:0];
			den_s3 <= dabs[M-1:0];
		end
	end

	assign ctl_o = ctl_s3;
	assign mag_o = mag_s3;
	assign den_o = den_s3;

endmodule

// ----- rtl/rau_gcd.sv -----
// Pipelined binary GCD: one reduction step per stage, then the shift-back stage.
// Depends on rau_pkg and the assertion macro header.
`include "rational_arith_unit_macros.svh"
module rau_gcd #(
	parameter int M = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rau_pkg::ctl_t ctl_i,
	input  logic [M-1:0]  mag_i,
	input  logic [M-1:0]  den_i,
	output rau_pkg::ctl_t ctl_o,
	output logic [M-1:0]  mag_o,
	output logic [M-1:0]  den_o,
	output logic [M-1:0]  g_o
);
	import rau_pkg::*;

	localparam int STEPS = 2 * M;
	localparam int KW    = $clog2(M + 1);

	ctl_t          ctl_s [1:STEPS];
	logic [M-1:0]  a_s   [1:STEPS];
	logic [M-1:0]  b_s   [1:STEPS];
	logic [KW-1:0] k_s   [1:STEPS];
	logic [M-1:0]  mag_s [1:STEPS];
	logic [M-1:0]  den_s [1:STEPS];

	for (genvar i = 1; i <= STEPS; i++) begin : g_step
		ctl_t          pc;
		logic [M-1:0]  pa, pb, pm, pd, na, nb;
		logic [KW-1:0] pk, nk;

		if (i == 1) begin : g_first
			assign pc = ctl_i;
			assign pa = mag_i;
			assign pb = den_i;
			assign pk = '0;
			assign pm = mag_i;
			assign pd = den_i;
		end else begin : g_next
			assign pc = ctl_s[i-1];
			assign pa = a_s[i-1];
			assign pb = b_s[i-1];
			assign pk = k_s[i-1];
			assign pm = mag_s[i-1];
			assign pd = den_s[i-1];
		end

		always_comb begin
			na = pa;
			nb = pb;
			nk = pk;
			priority if (pa == '0) begin
				na = pa;
			end else if (!pa[0] && !pb[0]) begin
				na = pa >> 1;
				nb = pb >> 1;
				nk = pk + KW'(1);
			end else if (!pa[0]) begin
				na = pa >> 1;
			end else if (!pb[0]) begin
				nb = pb >> 1;
			end else if (pa >= pb) begin
				na = (pa - pb) >> 1;
			end else begin
				nb = (pb - pa) >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= pc;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[i]   <= na;
				b_s[i]   <= nb;
				k_s[i]   <= nk;
				mag_s[i] <= pm;
				den_s[i] <= pd;
			end
		end
	end

	ctl_t         ctl_sn;
	logic [M-1:0] g_sn, mag_sn, den_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sn <= '0;
		end else if (en) begin
			ctl_sn <= ctl_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_sn   <= b_s[STEPS] << k_s[STEPS];
			mag_sn <= mag_s[STEPS];
			den_sn <= den_s[STEPS];
		end
	end

	assign ctl_o = ctl_sn;
	assign g_o   = g_sn;
	assign mag_o = mag_sn;
	assign den_o = den_sn;

	`RAU_ASSERT(a_gcd_done, clk, arst_n, ctl_s[STEPS].vld && ctl_s[STEPS].st == ST_OK |-> a_s[STEPS] == '0)

endmodule

// ----- rtl/rau_div.sv -----
// Twin restoring dividers (numerator and denominator by the GCD), one quotient
// bit per stage, plus the output register. Depends on rau_pkg.
module rau_div #(
	parameter int M = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  rau_pkg::ctl_t                      ctl_i,
	input  logic [M-1:0]                       mag_i,
	input  logic [M-1:0]                       den_i,
	input  logic [M-1:0]                       g_i,
	output logic                               vld_o,
	output logic signed [rau_pkg::FIELD_W-1:0] num_o,
	output logic [rau_pkg::DEN_W-1:0]          den_o,
	output logic [rau_pkg::ST_W-1:0]           st_o
);
	import rau_pkg::*;

	ctl_t         ctl_s [1:M];
	logic [M-1:0] rn_s  [1:M];
	logic [M-1:0] xn_s  [1:M];
	logic [M-1:0] rd_s  [1:M];
	logic [M-1:0] xd_s  [1:M];
	logic [M-1:0] g_s   [1:M];

	for (genvar i = 1; i <= M; i++) begin : g_bit
		ctl_t         pc;
		logic [M-1:0] prn, pxn, prd, pxd, pg;
		logic [M:0]   tn, td, dn, dd;
		logic         gen, ged;

		if (i == 1) begin : g_first
			assign pc  = ctl_i;
			assign prn = '0;
			assign pxn = mag_i;
			assign prd = '0;
			assign pxd = den_i;
			assign pg  = g_i;
		end else begin : g_next
			assign pc  = ctl_s[i-1];
			assign prn = rn_s[i-1];
			assign pxn = xn_s[i-1];
			assign prd = rd_s[i-1];
			assign pxd = xd_s[i-1];
			assign pg  = g_s[i-1];
		end

		assign tn  = {prn, pxn[M-1]};
		assign td  = {prd, pxd[M-1]};
		assign dn  = tn - {1'b0, pg};
		assign dd  = td - {1'b0, pg};
		assign gen = tn >= {1'b0, pg};
		assign ged = td >= {1'b0, pg};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= pc;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rn_s[i] <= gen ? dn[M-1:0] : tn[M-1:0];
				rd_s[i] <= ged ? dd[M-1:0] : td[M-1:0];
				xn_s[i] <= {pxn[M-2:0], gen};
				xd_s[i] <= {pxd[M-2:0], ged};
				g_s[i]  <= pg;
			end
		end
	end

	logic [M:0] qn, sn;
	logic       ok;

	assign ok = ctl_s[M].st == ST_OK;
	assign qn = {1'b0, xn_s[M]};
	assign sn = ctl_s[M].neg ? -qn : qn;

	logic                      vld_q;
	logic [ST_W-1:0]           st_q;
	logic signed [FIELD_W-1:0] num_q;
	logic [DEN_W-1:0]          den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctl_s[M].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q  <= ctl_s[M].st;
			num_q <= ok ? FIELD_W'(signed'(sn)) : '0;
			den_q <= ok ? DEN_W'(xd_s[M]) : '0;
		end
	end

	assign vld_o = vld_q;
	assign st_o  = st_q;
	assign num_o = num_q;
	assign den_o = den_q;

endmodule

// ----- rtl/rational_arith_unit.sv -----
// Rational arithmetic unit top level: front end, GCD pipeline, divider pipeline.
// Depends on rau_pkg, rau_front, rau_gcd, rau_div and the assertion macro header.
//
// Usage:
//   Input channel in_valid/in_ready carries opcode and two rationals
//   (first_num/first_den, second_num/second_den). Output channel
//   out_valid/out_ready returns result_num, result_den and status.
//   Each transaction yields exactly one result, in order.
// Pipeline: three front stages, 2*(EW-1) binary GCD steps, one shift-back stage,
//   EW-1 divider stages and the output register.
// Throughput: one transaction per cycle unless stalled; every stage is a register slice.
// Reset: arst_n clears all valid bits; the pipeline comes up empty.
// Stall: when out_valid is high and out_ready low, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// Errors return status with result_num and result_den both zero.
`include "rational_arith_unit_macros.svh"
module rational_arith_unit #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rau_pkg::OP_W-1:0]           opcode,
	input  logic signed [rau_pkg::FIELD_W-1:0] first_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] first_den,
	input  logic signed [rau_pkg::FIELD_W-1:0] second_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] second_den,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [rau_pkg::FIELD_W-1:0] result_num,
	output logic [rau_pkg::DEN_W-1:0]          result_den,
	output logic [rau_pkg::ST_W-1:0]           status
);
	import rau_pkg::*;

	localparam int EW = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
	localparam int M  = EW - 1;

	logic en;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	ctl_t         f_ctl, g_ctl;
	logic [M-1:0] f_mag, f_den, g_mag, g_den, g_g;

	rau_front #(.EW(EW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.first_num (first_num),
		.first_den (first_den),
		.second_num(second_num),
		.second_den(second_den),
		.ctl_o     (f_ctl),
		.mag_o     (f_mag),
		.den_o     (f_den)
	);

	rau_gcd #(.M(M)) u_gcd (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ctl_i (f_ctl),
		.mag_i (f_mag),
		.den_i (f_den),
		.ctl_o (g_ctl),
		.mag_o (g_mag),
		.den_o (g_den),
		.g_o   (g_g)
	);

	rau_div #(.M(M)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ctl_i (g_ctl),
		.mag_i (g_mag),
		.den_i (g_den),
		.g_i   (g_g),
		.vld_o (out_valid),
		.num_o (result_num),
		.den_o (result_den),
		.st_o  (status)
	);

	`RAU_ASSERT(a_err_zero, clk, arst_n, out_valid && status != ST_OK |-> result_num == '0 && result_den == '0)
	`RAU_ASSERT(a_ok_den, clk, arst_n, out_valid && status == ST_OK |-> result_den != '0)
	`RAU_ASSERT(a_zero_one, clk, arst_n, out_valid && status == ST_OK && result_num == '0 |-> result_den == DEN_W'(1))

endmodule
